// ----- src/mexp_pkg.sv -----
// Package for the modular exponentiation block: word types and controller states.
package mexp_pkg;

  // Width of the data fields in the input and result words
  localparam int unsigned FIELD_W = 32;

  // Input word: base, exponent, modulus
  typedef struct packed {
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent_value;
    logic [FIELD_W-1:0] modulus_value;
  } mexp_in_t;

  // Result word
  typedef struct packed {
    logic [FIELD_W-1:0] power_result;
    logic               modulus_error;
  } mexp_out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR
  } mexp_state_e;

endpackage

// ----- src/modular_exponentiation.sv -----
// Modular exponentiation top level: square-and-multiply over one bit-serial modmul unit.
//
// Usage: drive item_i and raise start while busy is low; the word is taken at that
// clock edge and, for a nonzero modulus, busy rises on the next cycle. One result
// word per input word appears on result_o, which done_o marks for exactly one cycle;
// the receiver cannot stall it. start may be raised again in the cycle done_o is high,
// since busy is low then. Operands are held to their low WIDTH bits. A zero modulus
// gives modulus_error = 1 and power_result = 0 in the cycle after the word is taken.
// Steps: reduce the base modulo the modulus, then for each of the WIDTH exponent bits,
// LSB first, multiply the result by the base when that bit is set and then square the
// base; the result is registered at the end. All steps use the single shared modular
// multiplier, which consumes one multiplier bit per cycle (double, reduce,
// conditionally add, reduce). One word is in flight at a time.
// Reset clears the controller and the strobe; data registers load on use.
module modular_exponentiation #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  mexp_pkg::mexp_in_t   item_i,
  output logic                 done_o,
  output mexp_pkg::mexp_out_t  result_o
);
  import mexp_pkg::*;

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(WIDTH - 1);

  mexp_state_e state_q, state_d;

  logic [WIDTH-1:0] mod_q, mod_d;      // modulus
  logic [WIDTH-1:0] base_q, base_d;    // running base (squared each exponent bit)
  logic [WIDTH-1:0] res_q, res_d;      // running result
  logic [WIDTH-1:0] exp_q, exp_d;      // exponent shift register, LSB first
  logic [WIDTH-1:0] acc_q, acc_d;      // modmul accumulator
  logic [WIDTH-1:0] mplr_q, mplr_d;    // multiplier bits, MSB first
  logic [CntW-1:0]  step_q, step_d;    // bit step within one modmul
  logic [CntW-1:0]  ebit_q, ebit_d;    // exponent bits left minus one
  logic             done_q, done_d;
  mexp_out_t        out_q, out_d;

  // Operands held to WIDTH bits
  logic [WIDTH-1:0] in_base, in_exp, in_mod;
  assign in_base = WIDTH'(64'(item_i.base_value));
  assign in_exp  = WIDTH'(64'(item_i.exponent_value));
  assign in_mod  = WIDTH'(64'(item_i.modulus_value));

  // One modmul step: shift in a bit, reduce, optionally add the base, reduce.
  logic [WIDTH:0]   dbl, dbl_red_w, sum;
  logic [WIDTH-1:0] dbl_red, sum_red, step_out;
  logic             shift_bit, add_en;

  always_comb begin
    shift_bit = (state_q == ST_REDUCE) ? mplr_q[WIDTH-1] : 1'b0;
    add_en    = (state_q != ST_REDUCE) && mplr_q[WIDTH-1];
    dbl       = {acc_q, shift_bit};
    dbl_red_w = (dbl >= {1'b0, mod_q}) ? (dbl - {1'b0, mod_q}) : dbl;
    dbl_red   = dbl_red_w[WIDTH-1:0];
    sum       = {1'b0, dbl_red} + {1'b0, base_q};
    sum_red   = (sum >= {1'b0, mod_q}) ? WIDTH'(sum - {1'b0, mod_q}) : sum[WIDTH-1:0];
    step_out  = add_en ? sum_red : dbl_red;
  end

  // Controller: next state and datapath loads
  always_comb begin
    state_d = state_q;
    mod_d   = mod_q;
    base_d  = base_q;
    res_d   = res_q;
    exp_d   = exp_q;
    acc_d   = step_out;
    mplr_d  = {mplr_q[WIDTH-2:0], 1'b0};
    step_d  = step_q - CntW'(1);
    ebit_d  = ebit_q;
    done_d  = 1'b0;
    out_d   = out_q;

    case (state_q)
      ST_IDLE: begin
        acc_d  = '0;
        mplr_d = in_base;
        step_d = LastIdx;
        ebit_d = LastIdx;
        mod_d  = in_mod;
        exp_d  = in_exp;
        res_d  = (in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
        if (start) begin
          if (in_mod == '0) begin
            done_d                 = 1'b1;
            out_d.power_result     = '0;
            out_d.modulus_error    = 1'b1;
          end else begin
            state_d = ST_REDUCE;
          end
        end
      end

      ST_REDUCE: begin
        if (step_q == '0) begin
          base_d = step_out;
          acc_d  = '0;
          step_d = LastIdx;
          if (exp_q[0]) begin
            state_d = ST_MUL;
            mplr_d  = res_q;
          end else begin
            state_d = ST_SQR;
            mplr_d  = step_out;
          end
        end
      end

      ST_MUL: begin
        if (step_q == '0) begin
          res_d   = step_out;
          acc_d   = '0;
          step_d  = LastIdx;
          state_d = ST_SQR;
          mplr_d  = base_q;
        end
      end

      ST_SQR: begin
        if (step_q == '0) begin
          base_d = step_out;
          acc_d  = '0;
          step_d = LastIdx;
          if (ebit_q == '0) begin
            state_d             = ST_IDLE;
            done_d              = 1'b1;
            out_d.power_result  = FIELD_W'(res_q);
            out_d.modulus_error = 1'b0;
          end else begin
            ebit_d = ebit_q - CntW'(1);
            exp_d  = {1'b0, exp_q[WIDTH-1:1]};
            if (exp_q[1]) begin
              state_d = ST_MUL;
              mplr_d  = res_q;
            end else begin
              state_d = ST_SQR;
              mplr_d  = step_out;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    mod_q  <= mod_d;
    base_q <= base_d;
    res_q  <= res_d;
    exp_q  <= exp_d;
    acc_q  <= acc_d;
    mplr_q <= mplr_d;
    step_q <= step_d;
    ebit_q <= ebit_d;
    out_q  <= out_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = out_q;

endmodule
